@@ design/mlfq_process_scheduler_core_defines.svh @@
// ---------------------------------------------------------------------------
// MLFQ scheduler assertion macros
// Assertion helpers for the scheduler core RTL.
// ---------------------------------------------------------------------------
`ifndef MLFQ_PROCESS_SCHEDULER_CORE_DEFINES_SVH
`define MLFQ_PROCESS_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTH
`define MLFQ_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("scheduler assertion failed");
`define MLFQ_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("scheduler assertion failed");
`else
`define MLFQ_ASSERT_NOW(lbl, pre, post)
`define MLFQ_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ design/mlfq_pkg.sv @@
// ---------------------------------------------------------------------------
// MLFQ scheduler package
// Constants, codes and types shared by the scheduler modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

    localparam int NUM_PROCS = 16;
    localparam int ID_W      = $clog2(NUM_PROCS);
    localparam int POS_W     = $clog2(NUM_PROCS + 1);
    localparam int LVL_W     = 8;
    localparam int ALLOT_W   = 20;
    localparam int BASE_W    = 10;
    localparam int TOP_W     = 5;
    localparam int PERIOD_W  = 16;
    localparam int TIME_W    = 32;
    localparam int DEPTH_W   = 8;
    localparam int CFG_W     = 16;

    localparam logic [ALLOT_W-1:0] ALLOT_MAX = {ALLOT_W{1'b1}};
    localparam logic [LVL_W-1:0]   LOWEST_LEVEL = LVL_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    localparam logic [1:0] CFG_BOOST_PERIOD = 2'd0;
    localparam logic [1:0] CFG_TOP_LEVEL    = 2'd1;
    localparam logic [1:0] CFG_BOOST_ALLOT  = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_RESCHED   = 2'd1,
        OP_DEFER_ON  = 2'd2,
        OP_DEFER_OFF = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_REM,
        CELL_SNAP
    } t_cell_op;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LVL_W-1:0] key;
    } t_cell_data;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
        t_cell_data       data;
    } t_cell_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RS_START,
        ST_RQ_EVAL,
        ST_MOD_WAIT,
        ST_BST_EVAL,
        ST_BST_NEXT,
        ST_DEM_START,
        ST_DEM_SEL,
        ST_DEM_EVAL,
        ST_DEM_NEXT,
        ST_REINS_REM,
        ST_REINS_INS,
        ST_PICK,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

@@ design/mlfq_cell.sv @@
// ---------------------------------------------------------------------------
// MLFQ ready list cell
// One slot of the ready list; shifts toward either neighbor on command.
// ---------------------------------------------------------------------------
`default_nettype none

module mlfq_cell (
    input  wire logic                   i_clk,
    input  wire logic [mlfq_pkg::POS_W-1:0] i_idx,
    input  wire mlfq_pkg::t_cell_cmd    i_cmd,
    input  wire mlfq_pkg::t_cell_data   i_left,
    input  wire mlfq_pkg::t_cell_data   i_right,
    output mlfq_pkg::t_cell_data        o_data,
    output logic [mlfq_pkg::ID_W-1:0]   o_snap,
    output logic                        o_match,
    output logic                        o_lower
);
    import mlfq_pkg::*;

    t_cell_data      r_data;
    t_cell_data      n_data;
    logic [ID_W-1:0] r_snap;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_INS: begin
                if (i_idx == i_cmd.pos) begin
                    n_data = i_cmd.data;
                end else if (i_idx > i_cmd.pos) begin
                    n_data = i_left;
                end
            end
            CELL_REM: begin
                if (i_idx >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_cmd.op == CELL_SNAP) begin
            r_snap <= r_data.id;
        end
    end

    assign o_data  = r_data;
    assign o_snap  = r_snap;
    assign o_match = (r_data.id == i_cmd.data.id);
    assign o_lower = (r_data.key < i_cmd.data.key);

endmodule

`default_nettype wire

@@ design/mlfq_mod.sv @@
// ---------------------------------------------------------------------------
// MLFQ boost period remainder unit
// Restoring bit-serial remainder of the time stamp by the boost period.
// ---------------------------------------------------------------------------
`default_nettype none

module mlfq_mod (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mlfq_pkg::TIME_W-1:0]   i_time,
    input  wire logic [mlfq_pkg::PERIOD_W-1:0] i_period,
    output logic                               o_busy,
    output logic                               o_zero
);
    import mlfq_pkg::*;

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [TIME_W-1:0]   r_q;
    logic [PERIOD_W-1:0] r_d;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;

    assign trial = {r_rem, r_q[TIME_W-1]};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(TIME_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_time;
            r_d   <= (i_period == '0) ? PERIOD_W'(1) : i_period;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[TIME_W-2:0], 1'b0};
            if (trial >= {1'b0, r_d}) begin
                r_rem <= diff[PERIOD_W-1:0];
            end else begin
                r_rem <= trial[PERIOD_W-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_zero = (r_rem == '0);

endmodule

`default_nettype wire

@@ design/mlfq_process_scheduler_core.sv @@
// Add words reinsert their process in the list. Defer start words and deferred reschedules go
// straight to finish, as do defer stop words unless one ends the last deferral with a pending
// reschedule. A reschedule runs the bit-serial boost remainder, the boost walk over the process
// table, the ready list walk for demotion and list reinsertions; one word is in work at a time.
// Reset is synchronous and active low; it empties the list and clears table and control state.
// ---------------------------------------------------------------------------
// MLFQ process scheduler core
// Sequencer over a process table and a row of ready list cells.
// ---------------------------------------------------------------------------
`default_nettype none

`include "mlfq_process_scheduler_core_defines.svh"

module mlfq_process_scheduler_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [3:0]  i_process_id,
    input  wire logic        i_is_user,
    input  wire logic [7:0]  i_priority_req,
    input  wire logic [9:0]  i_initial_allotment,
    input  wire logic [31:0] i_time_ms,
    input  wire logic        i_current_runnable,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_next_process,
    output logic             o_chosen_valid,
    output logic             o_switched,
    output logic             o_deferred,
    output logic             o_error,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import mlfq_pkg::*;

    t_state              r_state, n_state;
    t_state              r_ret;
    logic [ID_W-1:0]     r_p;
    logic [ID_W-1:0]     r_k;
    logic [POS_W-1:0]    r_n;
    logic [POS_W-1:0]    r_count;
    logic [ID_W-1:0]     r_run;
    logic                r_run_v;
    logic [DEPTH_W-1:0]  r_depth;
    logic                r_pend;
    logic [TIME_W-1:0]   r_time;
    logic                r_runnable;
    logic [PERIOD_W-1:0] r_period;
    logic [TOP_W-1:0]    r_top;
    logic [BASE_W-1:0]   r_boost_allot;

    logic [ID_W-1:0]     r_res_nxt;
    logic                r_res_cv, r_res_sw, r_res_df, r_res_er;
    logic                r_ovalid;
    logic [ID_W-1:0]     r_o_nxt;
    logic                r_o_cv, r_o_sw, r_o_df, r_o_er;

    logic                r_user  [NUM_PROCS];
    logic [LVL_W-1:0]    r_level [NUM_PROCS];
    logic [ALLOT_W-1:0]  r_allot [NUM_PROCS];
    logic [BASE_W-1:0]   r_base  [NUM_PROCS];

    t_cell_cmd           cell_cmd;
    t_cell_data          cell_q    [NUM_PROCS];
    t_cell_data          cell_left [NUM_PROCS];
    t_cell_data          cell_right[NUM_PROCS];
    logic [ID_W-1:0]     cell_snap [NUM_PROCS];
    logic                cell_match[NUM_PROCS];
    logic                cell_lower[NUM_PROCS];

    logic                in_acc;
    logic                out_free;
    logic                rem_hit;
    logic [POS_W-1:0]    rem_pos;
    logic [POS_W-1:0]    ins_pos;
    logic                mod_start, mod_busy, mod_zero;

    logic                tbl_we;
    logic [ID_W-1:0]     tbl_addr;
    logic                tbl_user;
    logic [LVL_W-1:0]    tbl_level;
    logic [ALLOT_W-1:0]  tbl_allot;
    logic                tbl_base_we;

    logic                p_user;
    logic [LVL_W-1:0]    p_level;
    logic [ALLOT_W-1:0]  p_allot;
    logic [BASE_W-1:0]   p_base;
    logic [LVL_W-1:0]    top_ext;
    logic [LVL_W-1:0]    shift_amt;
    logic [BASE_W+31:0]  shifted;
    logic [ALLOT_W-1:0]  demote_allot;
    logic                do_boost, do_demote;

    assign p_user  = r_user[r_p];
    assign p_level = r_level[r_p];
    assign p_allot = r_allot[r_p];
    assign p_base  = r_base[r_p];
    assign top_ext = LVL_W'(r_top);

    assign shift_amt = (p_level < top_ext) ? (top_ext - p_level) : '0;
    assign shifted   = (BASE_W+32)'(p_base) << shift_amt[4:0];
    assign demote_allot = (|shifted[BASE_W+31:ALLOT_W]) ? ALLOT_MAX : shifted[ALLOT_W-1:0];

    assign do_boost  = p_user && (p_level < top_ext);
    assign do_demote = p_user && (p_allot == '0) && (p_level > LOWEST_LEVEL);

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;

    genvar g;
    generate
        for (g = 0; g < NUM_PROCS; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign cell_left[g] = '0;
            end else begin : g_mid
                assign cell_left[g] = cell_q[g-1];
            end
            if (g == NUM_PROCS - 1) begin : g_last
                assign cell_right[g] = '0;
            end else begin : g_body
                assign cell_right[g] = cell_q[g+1];
            end
            mlfq_cell u_cell (
                .i_clk   (i_clk),
                .i_idx   (POS_W'(g)),
                .i_cmd   (cell_cmd),
                .i_left  (cell_left[g]),
                .i_right (cell_right[g]),
                .o_data  (cell_q[g]),
                .o_snap  (cell_snap[g]),
                .o_match (cell_match[g]),
                .o_lower (cell_lower[g])
            );
        end
    endgenerate

    mlfq_mod u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_time   (r_time),
        .i_period (r_period),
        .o_busy   (mod_busy),
        .o_zero   (mod_zero)
    );

    always_comb begin
        rem_hit = 1'b0;
        rem_pos = '0;
        ins_pos = r_count;
        for (int k = NUM_PROCS - 1; k >= 0; k--) begin
            if (POS_W'(k) < r_count) begin
                if (cell_match[k]) begin
                    rem_hit = 1'b1;
                    rem_pos = POS_W'(k);
                end
                if (cell_lower[k]) begin
                    ins_pos = POS_W'(k);
                end
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        cell_cmd.op     = CELL_HOLD;
        cell_cmd.pos    = '0;
        cell_cmd.data.id  = r_p;
        cell_cmd.data.key = p_level;
        mod_start       = 1'b0;
        tbl_we          = 1'b0;
        tbl_base_we     = 1'b0;
        tbl_addr        = r_p;
        tbl_user        = p_user;
        tbl_level       = p_level;
        tbl_allot       = p_allot;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_operation))
                        OP_ADD: begin
                            tbl_we      = 1'b1;
                            tbl_base_we = 1'b1;
                            tbl_addr    = i_process_id;
                            tbl_user    = i_is_user;
                            tbl_level   = i_priority_req;
                            tbl_allot   = ALLOT_W'(i_initial_allotment);
                            n_state     = ST_REINS_REM;
                        end
                        OP_RESCHED: begin
                            n_state = (r_depth != '0) ? ST_FIN : ST_RS_START;
                        end
                        OP_DEFER_ON: n_state = ST_FIN;
                        OP_DEFER_OFF: begin
                            if (r_depth == DEPTH_W'(1) && r_pend) begin
                                n_state = ST_RS_START;
                            end else begin
                                n_state = ST_FIN;
                            end
                        end
                        default: n_state = ST_FIN;
                    endcase
                end
            end
            ST_RS_START: begin
                mod_start = 1'b1;
                n_state   = (r_run_v && r_runnable) ? ST_RQ_EVAL : ST_MOD_WAIT;
            end
            ST_RQ_EVAL: begin
                if (p_user && p_level > LOWEST_LEVEL && p_allot != '0) begin
                    tbl_we    = 1'b1;
                    tbl_allot = p_allot - ALLOT_W'(1);
                end
                n_state = ST_REINS_REM;
            end
            ST_MOD_WAIT: begin
                if (!mod_busy) begin
                    n_state = mod_zero ? ST_BST_EVAL : ST_DEM_START;
                end
            end
            ST_BST_EVAL: begin
                if (do_boost) begin
                    tbl_we    = 1'b1;
                    tbl_level = top_ext;
                    tbl_allot = ALLOT_W'(r_boost_allot);
                    n_state   = rem_hit ? ST_REINS_REM : ST_BST_NEXT;
                end else begin
                    n_state = ST_BST_NEXT;
                end
            end
            ST_BST_NEXT: begin
                n_state = (r_p == ID_W'(NUM_PROCS - 1)) ? ST_DEM_START : ST_BST_EVAL;
            end
            ST_DEM_START: begin
                cell_cmd.op = CELL_SNAP;
                n_state     = (r_count == '0) ? ST_PICK : ST_DEM_SEL;
            end
            ST_DEM_SEL: n_state = ST_DEM_EVAL;
            ST_DEM_EVAL: begin
                if (do_demote) begin
                    tbl_we    = 1'b1;
                    tbl_level = p_level - LVL_W'(1);
                    tbl_allot = demote_allot;
                    n_state   = ST_REINS_REM;
                end else begin
                    n_state = ST_DEM_NEXT;
                end
            end
            ST_DEM_NEXT: begin
                n_state = ((POS_W'(r_k) + POS_W'(1)) >= r_n) ? ST_PICK : ST_DEM_SEL;
            end
            ST_REINS_REM: begin
                if (rem_hit) begin
                    cell_cmd.op  = CELL_REM;
                    cell_cmd.pos = rem_pos;
                end
                n_state = ST_REINS_INS;
            end
            ST_REINS_INS: begin
                cell_cmd.op  = CELL_INS;
                cell_cmd.pos = ins_pos;
                n_state      = r_ret;
            end
            ST_PICK: begin
                if (r_count != '0) begin
                    cell_cmd.op  = CELL_REM;
                    cell_cmd.pos = '0;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                r_user[i]  <= 1'b0;
                r_level[i] <= '0;
                r_allot[i] <= '0;
                r_base[i]  <= '0;
            end
        end else if (tbl_we) begin
            r_user[tbl_addr]  <= tbl_user;
            r_level[tbl_addr] <= tbl_level;
            r_allot[tbl_addr] <= tbl_allot;
            if (tbl_base_we) begin
                r_base[tbl_addr] <= i_initial_allotment;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= PERIOD_W'(50);
            r_top         <= TOP_W'(3);
            r_boost_allot <= BASE_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOOST_PERIOD: r_period      <= i_cfg_data;
                CFG_TOP_LEVEL:    r_top         <= i_cfg_data[TOP_W-1:0];
                CFG_BOOST_ALLOT:  r_boost_allot <= i_cfg_data[BASE_W-1:0];
                default:          r_period      <= r_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_run    <= '0;
            r_run_v  <= 1'b0;
            r_depth  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_ret    <= ST_IDLE;
        end else begin
            if (r_state == ST_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_ret <= ST_FIN;
                        case (t_op'(i_operation))
                            OP_RESCHED: begin
                                if (r_depth != '0) begin
                                    r_pend <= 1'b1;
                                end
                            end
                            OP_DEFER_ON: begin
                                if (r_depth == '0) begin
                                    r_pend <= 1'b0;
                                end
                                if (r_depth != DEPTH_MAX) begin
                                    r_depth <= r_depth + DEPTH_W'(1);
                                end
                            end
                            OP_DEFER_OFF: begin
                                if (r_depth != '0) begin
                                    r_depth <= r_depth - DEPTH_W'(1);
                                end
                            end
                            default: r_pend <= r_pend;
                        endcase
                    end
                end
                ST_RQ_EVAL:  r_ret <= ST_MOD_WAIT;
                ST_BST_EVAL: r_ret <= ST_BST_NEXT;
                ST_DEM_EVAL: r_ret <= ST_DEM_NEXT;
                ST_DEM_START: r_ret <= ST_DEM_NEXT;
                ST_REINS_REM: begin
                    if (rem_hit) begin
                        r_count <= r_count - POS_W'(1);
                    end
                end
                ST_REINS_INS: r_count <= r_count + POS_W'(1);
                ST_PICK: begin
                    if (r_count == '0) begin
                        r_run_v <= 1'b0;
                    end else begin
                        r_run   <= cell_q[0].id;
                        r_run_v <= 1'b1;
                        r_count <= r_count - POS_W'(1);
                    end
                end
                default: r_ret <= r_ret;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_p        <= i_process_id;
                    r_time     <= i_time_ms;
                    r_runnable <= i_current_runnable;
                    r_res_nxt  <= '0;
                    r_res_cv   <= 1'b0;
                    r_res_sw   <= 1'b0;
                    r_res_df   <= (t_op'(i_operation) == OP_RESCHED) && (r_depth != '0);
                    r_res_er   <= (t_op'(i_operation) == OP_DEFER_OFF) && (r_depth == '0);
                end
            end
            ST_RS_START: r_p <= r_run;
            ST_MOD_WAIT: r_p <= '0;
            ST_BST_NEXT: r_p <= r_p + ID_W'(1);
            ST_DEM_START: begin
                r_n <= r_count;
                r_k <= '0;
            end
            ST_DEM_SEL:  r_p <= cell_snap[r_k];
            ST_DEM_NEXT: r_k <= r_k + ID_W'(1);
            ST_PICK: begin
                if (r_count != '0) begin
                    r_res_nxt <= cell_q[0].id;
                    r_res_cv  <= 1'b1;
                    r_res_sw  <= !r_run_v || (r_run != cell_q[0].id);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    r_o_nxt <= r_res_nxt;
                    r_o_cv  <= r_res_cv;
                    r_o_sw  <= r_res_sw;
                    r_o_df  <= r_res_df;
                    r_o_er  <= r_res_er;
                end
            end
            default: r_p <= r_p;
        endcase
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_next_process = r_o_nxt;
    assign o_chosen_valid = r_o_cv;
    assign o_switched     = r_o_sw;
    assign o_deferred     = r_o_df;
    assign o_error        = r_o_er;

    `MLFQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= POS_W'(NUM_PROCS))
    `MLFQ_ASSERT_NEXT(a_pick_runs, (r_state == ST_PICK) && (r_count != '0), r_run_v)
    `MLFQ_ASSERT_NOW(a_chosen_flags, o_out_valid && o_chosen_valid, !o_deferred && !o_error)
    `MLFQ_ASSERT_NEXT(a_empty_pick, (r_state == ST_PICK) && (r_count == '0), !r_run_v)

endmodule

`default_nettype wire
